### sv/wasr_pkg.sv
// ----------------------------------------------------------------------------
// Waypoint route search package
// Shared constants, codes and state encoding for the waypoint route search.
// ----------------------------------------------------------------------------
package wasr_pkg;

  localparam int unsigned DEF_MAX_POINTS    = 32;
  localparam int unsigned DEF_MAX_NEIGHBORS = 8;
  localparam int unsigned DEF_COORD_BITS    = 16;

  // Width of the link index fields of an input beat.
  localparam int unsigned LINK_BITS = 5;

  // Path costs and estimates are unsigned and saturate at their maximum.
  localparam int unsigned COST_BITS = 24;
  localparam logic [COST_BITS-1:0] COST_MAX = '1;

  typedef enum logic [1:0] {
    ACT_ADD_POINT = 2'd0,
    ACT_ADD_LINK  = 2'd1,
    ACT_ROUTE     = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NO_ROUTE  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_LINK,
    S_EMIT,
    S_N_RD,
    S_N_LD,
    S_N_FROM,
    S_N_GOAL,
    S_I_RDS,
    S_I_RDE,
    S_I_LDE,
    S_I_DONE,
    S_SC_RD,
    S_SC_CMP,
    S_SC_END,
    S_X_RD,
    S_X_LD,
    S_X_NB,
    S_X_NBW,
    S_X_NBP,
    S_X_G,
    S_X_H,
    S_P_GOAL,
    S_P_RD,
    S_P_EM,
    S_SQ_MUL,
    S_SQ_ACC,
    S_SQ_ROOT
  } state_e;

endpackage

### sv/wasr_if.sv
// ----------------------------------------------------------------------------
// Waypoint route search channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface wasr_in_if #(
  parameter int unsigned COORD_BITS = wasr_pkg::DEF_COORD_BITS
);
  logic                             valid;
  logic                             ready;
  logic [1:0]                       action;
  logic signed [COORD_BITS-1:0]     pos_x;
  logic signed [COORD_BITS-1:0]     pos_y;
  logic signed [COORD_BITS-1:0]     pos_z;
  logic signed [COORD_BITS-1:0]     goal_x;
  logic signed [COORD_BITS-1:0]     goal_y;
  logic signed [COORD_BITS-1:0]     goal_z;
  logic [wasr_pkg::LINK_BITS-1:0]   link_src;
  logic [wasr_pkg::LINK_BITS-1:0]   link_dst;

  modport source (
    output valid, action, pos_x, pos_y, pos_z, goal_x, goal_y, goal_z,
           link_src, link_dst,
    input  ready
  );
  modport sink (
    input  valid, action, pos_x, pos_y, pos_z, goal_x, goal_y, goal_z,
           link_src, link_dst,
    output ready
  );
endinterface

interface wasr_out_if #(
  parameter int unsigned COORD_BITS = wasr_pkg::DEF_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;
  logic                         last;
  logic [1:0]                   status;

  modport source (output valid, out_x, out_y, out_z, last, status, input ready);
  modport sink   (input valid, out_x, out_y, out_z, last, status, output ready);
endinterface

### sv/waypoint_astar_route_search.sv
// ----------------------------------------------------------------------------
// Waypoint route search
// Waypoint store with directed links and an A* route search over it.
// ----------------------------------------------------------------------------
// Add-waypoint and add-link requests each give one result beat. A route request
// first snaps start and goal to their nearest waypoints, then per expansion scans
// every stored waypoint for the open-list entry and relaxes the links of the
// expanded waypoint, with two square roots per relaxed link.
// Results leave one beat at a time; one request is worked at a time.
// Reset (async, active low) clears the waypoint count and open/closed marks.
module waypoint_astar_route_search #(
  parameter int unsigned MAX_POINTS    = wasr_pkg::DEF_MAX_POINTS,
  parameter int unsigned MAX_NEIGHBORS = wasr_pkg::DEF_MAX_NEIGHBORS,
  parameter int unsigned COORD_BITS    = wasr_pkg::DEF_COORD_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  wasr_in_if.sink    in_i,
  wasr_out_if.source out_o
);
  import wasr_pkg::*;

  // Index and count widths. A count must hold MAX_POINTS itself.
  localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW   = $clog2(MAX_POINTS);
  localparam int unsigned NCW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned TW   = $clog2(MAX_POINTS * MAX_NEIGHBORS);
  localparam int unsigned IXW  = (CW > LINK_BITS) ? CW : LINK_BITS;
  localparam int unsigned PW   = 3 * COORD_BITS;
  // A coordinate difference needs one extra bit; the squared length of a
  // 3D difference stays below 2^(2*COORD_BITS+2).
  localparam int unsigned RW   = COORD_BITS + 1;
  localparam int unsigned SW   = 2 * RW;
  localparam int unsigned SUMW = ((COST_BITS > RW) ? COST_BITS : RW) + 1;

  // Saturating cost addition.
  function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                   input logic [RW-1:0] b);
    logic [SUMW-1:0] s;
    s = SUMW'(a) + SUMW'(b);
    return (s > SUMW'(COST_MAX)) ? COST_MAX : s[COST_BITS-1:0];
  endfunction

  // Memories: synchronous write, registered read.
  logic [PW-1:0]        pos_mem  [MAX_POINTS];
  logic [NCW-1:0]       ncnt_mem [MAX_POINTS];
  logic [LINK_BITS-1:0] tbl_mem  [MAX_POINTS*MAX_NEIGHBORS];
  logic [COST_BITS-1:0] pc_mem   [MAX_POINTS];
  logic [COST_BITS-1:0] te_mem   [MAX_POINTS];
  logic [AW-1:0]        cf_mem   [MAX_POINTS];

  logic [PW-1:0]        pos_rd_q;
  logic [NCW-1:0]       ncnt_rd_q;
  logic [LINK_BITS-1:0] tbl_rd_q;
  logic [COST_BITS-1:0] pc_rd_q;
  logic [COST_BITS-1:0] te_rd_q;
  logic [AW-1:0]        cf_rd_q;

  logic [AW-1:0] pos_raddr, ncnt_raddr, pc_raddr, te_raddr, cf_raddr;
  logic [TW-1:0] tbl_raddr;

  // Control state.
  state_e state_q, state_d;
  logic [CW-1:0]         count_q;
  logic [MAX_POINTS-1:0] open_q;
  logic [MAX_POINTS-1:0] closed_q;

  // Request capture.
  logic [1:0]           act_q;
  logic [PW-1:0]        from_q, goal_q;
  logic [LINK_BITS-1:0] src_q, dst_q;

  // Search datapath.
  logic [CW-1:0]        idx_q;
  logic [AW-1:0]        s_q, e_q;
  logic [SW-1:0]        bd_s_q, bd_e_q;
  logic [AW-1:0]        cur_q;
  logic                 curv_q;
  logic [COST_BITS-1:0] bte_q;
  logic [NCW-1:0]       k_q, ncnt_q;
  logic [PW-1:0]        cur_pos_q, nb_pos_q, e_pos_q;
  logic [COST_BITS-1:0] cur_cost_q, nb_pc_q, nc_q;
  logic [AW-1:0]        nb_q;
  logic [AW-1:0]        wp_q;
  logic [CW-1:0]        steps_q;

  // Squared-distance engine and its return point.
  logic [PW-1:0] op_a_q, op_b_q;
  logic [1:0]    sqk_q;
  logic [SW-1:0] prod_q, acc_q;
  logic          want_root_q;
  state_e        ret_q;

  // Pending result beat and the output register.
  logic [PW-1:0] emit_pos_q;
  logic          emit_last_q;
  status_e       emit_st_q;
  state_e        emit_ret_q;
  logic          out_valid_q;
  logic [PW-1:0] out_pos_q;
  logic          out_last_q;
  status_e       out_st_q;

  // Combinational helpers.
  logic                  emit_go;
  logic [IXW-1:0]        src_x, dst_x, nb_x, count_x;
  logic [AW-1:0]         src_i, nb_i;
  logic                  link_bad, nb_skip, relax, path_end;
  logic [COST_BITS-1:0]  nc_w;
  logic signed [RW-1:0]  da, db, dd;
  logic signed [SW-1:0]  sq;
  logic [SW-1:0]         acc_sum;
  logic                  sq_start, sq_busy;
  logic [RW-1:0]         root;

  assign src_x    = IXW'(src_q);
  assign dst_x    = IXW'(dst_q);
  assign nb_x     = IXW'(tbl_rd_q);
  assign count_x  = IXW'(count_q);
  assign src_i    = src_x[AW-1:0];
  assign nb_i     = nb_x[AW-1:0];
  assign link_bad = (src_x >= count_x) || (dst_x >= count_x);
  assign nb_skip  = (nb_x >= count_x) || closed_q[nb_i];
  assign nc_w     = sat_add(cur_cost_q, root);
  assign relax    = (nc_w < nb_pc_q) || !open_q[nb_q];
  assign path_end = (wp_q == s_q) || ((steps_q + CW'(1)) == count_q);
  assign emit_go  = !out_valid_q || out_o.ready;

  // One coordinate of the difference at a time, squared on one multiplier.
  assign da      = {op_a_q[sqk_q*COORD_BITS + COORD_BITS - 1],
                    op_a_q[sqk_q*COORD_BITS +: COORD_BITS]};
  assign db      = {op_b_q[sqk_q*COORD_BITS + COORD_BITS - 1],
                    op_b_q[sqk_q*COORD_BITS +: COORD_BITS]};
  assign dd      = da - db;
  assign sq      = dd * dd;
  assign acc_sum = acc_q + prod_q;
  assign sq_start = (state_q == S_SQ_ACC) && (sqk_q == 2'd2) && want_root_q;

  wasr_isqrt #(
    .ROOT_BITS (RW)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (acc_sum),
    .busy_o     (sq_busy),
    .root_o     (root)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_i.valid) state_d = S_DISP;
      S_DISP: begin
        case (action_e'(act_q))
          ACT_ADD_POINT: state_d = S_EMIT;
          ACT_ADD_LINK:  state_d = S_LINK;
          ACT_ROUTE:     state_d = (count_q == '0) ? S_EMIT : S_N_RD;
          default:       state_d = S_IDLE;
        endcase
      end
      S_LINK:    state_d = S_EMIT;
      S_EMIT:    if (emit_go) state_d = emit_ret_q;
      S_N_RD:    state_d = S_N_LD;
      S_N_LD:    state_d = S_SQ_MUL;
      S_N_FROM:  state_d = S_SQ_MUL;
      S_N_GOAL:  state_d = ((idx_q + CW'(1)) == count_q) ? S_I_RDS : S_N_RD;
      S_I_RDS:   state_d = S_I_RDE;
      S_I_RDE:   state_d = S_I_LDE;
      S_I_LDE:   state_d = S_SQ_MUL;
      S_I_DONE:  state_d = S_SC_RD;
      S_SC_RD:   state_d = S_SC_CMP;
      S_SC_CMP:  state_d = ((idx_q + CW'(1)) == count_q) ? S_SC_END : S_SC_RD;
      S_SC_END: begin
        if (!curv_q)         state_d = S_EMIT;
        else if (cur_q == e_q) state_d = S_P_GOAL;
        else                 state_d = S_X_RD;
      end
      S_X_RD:    state_d = S_X_LD;
      S_X_LD:    state_d = S_X_NB;
      S_X_NB:    state_d = (k_q == ncnt_q) ? S_SC_RD : S_X_NBW;
      S_X_NBW:   state_d = nb_skip ? S_X_NB : S_X_NBP;
      S_X_NBP:   state_d = S_SQ_MUL;
      S_X_G:     state_d = relax ? S_SQ_MUL : S_X_NB;
      S_X_H:     state_d = S_X_NB;
      S_P_GOAL:  state_d = S_EMIT;
      S_P_RD:    state_d = S_P_EM;
      S_P_EM:    state_d = S_EMIT;
      S_SQ_MUL:  state_d = S_SQ_ACC;
      S_SQ_ACC: begin
        if (sqk_q != 2'd2)   state_d = S_SQ_MUL;
        else if (want_root_q) state_d = S_SQ_ROOT;
        else                 state_d = ret_q;
      end
      S_SQ_ROOT: if (!sq_busy) state_d = ret_q;
      default:   state_d = S_IDLE;
    endcase
  end

  // Memory read addresses.
  always_comb begin
    pos_raddr  = '0;
    ncnt_raddr = '0;
    pc_raddr   = '0;
    te_raddr   = '0;
    cf_raddr   = '0;
    tbl_raddr  = '0;
    case (state_q)
      S_DISP:  ncnt_raddr = src_i;
      S_N_RD:  pos_raddr  = idx_q[AW-1:0];
      S_I_RDS: pos_raddr  = s_q;
      S_I_RDE: pos_raddr  = e_q;
      S_SC_RD: te_raddr   = idx_q[AW-1:0];
      S_X_RD: begin
        pos_raddr  = cur_q;
        ncnt_raddr = cur_q;
        pc_raddr   = cur_q;
      end
      S_X_NB:  tbl_raddr = TW'(TW'(cur_q) * TW'(MAX_NEIGHBORS) + TW'(k_q));
      S_X_NBW: begin
        pos_raddr = nb_i;
        pc_raddr  = nb_i;
      end
      S_P_RD: begin
        pos_raddr = wp_q;
        cf_raddr  = wp_q;
      end
      default: ;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      open_q   <= '0;
      closed_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_DISP: begin
          if (action_e'(act_q) == ACT_ADD_POINT && count_q < CW'(MAX_POINTS)) begin
            count_q <= count_q + CW'(1);
          end
          if (action_e'(act_q) == ACT_ROUTE) begin
            open_q   <= '0;
            closed_q <= '0;
          end
        end
        S_I_DONE: open_q[s_q] <= 1'b1;
        S_SC_END: begin
          if (curv_q) begin
            open_q[cur_q]   <= 1'b0;
            closed_q[cur_q] <= 1'b1;
          end
        end
        S_X_H:   open_q[nb_q] <= 1'b1;
        default: ;
      endcase
    end
  end

  // Memories and datapath registers.
  always_ff @(posedge clk_i) begin
    pos_rd_q  <= pos_mem[pos_raddr];
    ncnt_rd_q <= ncnt_mem[ncnt_raddr];
    tbl_rd_q  <= tbl_mem[tbl_raddr];
    pc_rd_q   <= pc_mem[pc_raddr];
    te_rd_q   <= te_mem[te_raddr];
    cf_rd_q   <= cf_mem[cf_raddr];

    case (state_q)
      S_IDLE: begin
        act_q  <= in_i.action;
        from_q <= {in_i.pos_z, in_i.pos_y, in_i.pos_x};
        goal_q <= {in_i.goal_z, in_i.goal_y, in_i.goal_x};
        src_q  <= in_i.link_src;
        dst_q  <= in_i.link_dst;
      end
      S_DISP: begin
        emit_pos_q  <= '0;
        emit_last_q <= 1'b1;
        emit_ret_q  <= S_IDLE;
        emit_st_q   <= ST_OK;
        idx_q       <= '0;
        case (action_e'(act_q))
          ACT_ADD_POINT: begin
            if (count_q >= CW'(MAX_POINTS)) begin
              emit_st_q <= ST_FULL;
            end else begin
              pos_mem[count_q[AW-1:0]]  <= from_q;
              ncnt_mem[count_q[AW-1:0]] <= '0;
            end
          end
          ACT_ROUTE: if (count_q == '0) emit_st_q <= ST_NO_ROUTE;
          default: ;
        endcase
      end
      S_LINK: begin
        if (link_bad) begin
          emit_st_q <= ST_BAD_INDEX;
        end else if (ncnt_rd_q >= NCW'(MAX_NEIGHBORS)) begin
          emit_st_q <= ST_FULL;
        end else begin
          tbl_mem[TW'(TW'(src_i) * TW'(MAX_NEIGHBORS) + TW'(ncnt_rd_q))] <= dst_q;
          ncnt_mem[src_i] <= ncnt_rd_q + NCW'(1);
        end
      end
      // Nearest waypoint to the start and to the goal, lowest index on a tie.
      S_N_LD: begin
        op_a_q      <= pos_rd_q;
        op_b_q      <= from_q;
        acc_q       <= '0;
        sqk_q       <= '0;
        want_root_q <= 1'b0;
        ret_q       <= S_N_FROM;
      end
      S_N_FROM: begin
        if (idx_q == '0 || acc_q < bd_s_q) begin
          bd_s_q <= acc_q;
          s_q    <= idx_q[AW-1:0];
        end
        op_b_q <= goal_q;
        acc_q  <= '0;
        sqk_q  <= '0;
        ret_q  <= S_N_GOAL;
      end
      S_N_GOAL: begin
        if (idx_q == '0 || acc_q < bd_e_q) begin
          bd_e_q <= acc_q;
          e_q    <= idx_q[AW-1:0];
        end
        idx_q <= idx_q + CW'(1);
      end
      S_I_RDE: op_a_q <= pos_rd_q;
      S_I_LDE: begin
        op_b_q      <= pos_rd_q;
        e_pos_q     <= pos_rd_q;
        acc_q       <= '0;
        sqk_q       <= '0;
        want_root_q <= 1'b1;
        ret_q       <= S_I_DONE;
      end
      S_I_DONE: begin
        pc_mem[s_q] <= '0;
        te_mem[s_q] <= sat_add('0, root);
        idx_q       <= '0;
        curv_q      <= 1'b0;
      end
      // Open-list scan: strict compare keeps the lowest index on a tie.
      S_SC_CMP: begin
        if (open_q[idx_q[AW-1:0]] && (!curv_q || te_rd_q < bte_q)) begin
          cur_q  <= idx_q[AW-1:0];
          bte_q  <= te_rd_q;
          curv_q <= 1'b1;
        end
        idx_q <= idx_q + CW'(1);
      end
      S_SC_END: begin
        emit_pos_q  <= '0;
        emit_last_q <= 1'b1;
        emit_st_q   <= ST_NO_ROUTE;
        emit_ret_q  <= S_IDLE;
      end
      S_X_LD: begin
        cur_pos_q  <= pos_rd_q;
        cur_cost_q <= pc_rd_q;
        ncnt_q     <= ncnt_rd_q;
        k_q        <= '0;
      end
      S_X_NB: begin
        if (k_q == ncnt_q) begin
          idx_q  <= '0;
          curv_q <= 1'b0;
        end
      end
      S_X_NBW: begin
        nb_q <= nb_i;
        if (nb_skip) k_q <= k_q + NCW'(1);
      end
      S_X_NBP: begin
        op_a_q      <= cur_pos_q;
        op_b_q      <= pos_rd_q;
        nb_pos_q    <= pos_rd_q;
        nb_pc_q     <= pc_rd_q;
        acc_q       <= '0;
        sqk_q       <= '0;
        want_root_q <= 1'b1;
        ret_q       <= S_X_G;
      end
      S_X_G: begin
        if (relax) begin
          nc_q   <= nc_w;
          op_a_q <= nb_pos_q;
          op_b_q <= e_pos_q;
          acc_q  <= '0;
          sqk_q  <= '0;
          ret_q  <= S_X_H;
        end else begin
          k_q <= k_q + NCW'(1);
        end
      end
      S_X_H: begin
        pc_mem[nb_q] <= nc_q;
        te_mem[nb_q] <= sat_add(nc_q, root);
        cf_mem[nb_q] <= cur_q;
        k_q          <= k_q + NCW'(1);
      end
      // Route out: the goal position, then waypoints back to the start.
      S_P_GOAL: begin
        emit_pos_q  <= goal_q;
        emit_last_q <= 1'b0;
        emit_st_q   <= ST_OK;
        emit_ret_q  <= S_P_RD;
        wp_q        <= e_q;
        steps_q     <= '0;
      end
      S_P_EM: begin
        emit_pos_q  <= pos_rd_q;
        emit_last_q <= path_end;
        emit_st_q   <= ST_OK;
        emit_ret_q  <= path_end ? S_IDLE : S_P_RD;
        wp_q        <= cf_rd_q;
        steps_q     <= steps_q + CW'(1);
      end
      S_SQ_MUL: prod_q <= SW'(unsigned'(sq));
      S_SQ_ACC: begin
        acc_q <= acc_sum;
        sqk_q <= sqk_q + 2'd1;
      end
      default: ;
    endcase
  end

  // Output register: holds a beat until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && emit_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && emit_go) begin
      out_pos_q  <= emit_pos_q;
      out_last_q <= emit_last_q;
      out_st_q   <= emit_st_q;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.out_x  = out_pos_q[0 +: COORD_BITS];
  assign out_o.out_y  = out_pos_q[COORD_BITS +: COORD_BITS];
  assign out_o.out_z  = out_pos_q[2*COORD_BITS +: COORD_BITS];
  assign out_o.last   = out_last_q;
  assign out_o.status = out_st_q;

  // A node is never open and closed at once.
  a_open_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q & closed_q) == '0)
    else $error("node both open and closed");

  // The square-root unit is only started when it is free.
  a_sqrt_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_busy)
    else $error("square root started while busy");

  // The waypoint count never passes the store size.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_POINTS))
    else $error("waypoint count overflow");

  // An expanded node has been moved to the closed set.
  a_expand_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_X_RD) |-> closed_q[cur_q] && !open_q[cur_q])
    else $error("expanded node not closed");
endmodule

### sv/wasr_isqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root, one result bit per cycle, restoring digit recurrence.
// ----------------------------------------------------------------------------
module wasr_isqrt #(
  parameter int unsigned ROOT_BITS = wasr_pkg::DEF_COORD_BITS + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [2*ROOT_BITS-1:0]   radicand_i,
  output logic                     busy_o,
  output logic [ROOT_BITS-1:0]     root_o
);
  localparam int unsigned CntW = $clog2(ROOT_BITS + 1);

  logic [2*ROOT_BITS-1:0] rad_q;
  logic [ROOT_BITS+1:0]   rem_q;
  logic [ROOT_BITS-1:0]   root_q;
  logic [CntW-1:0]        cnt_q;
  logic                   busy_q;
  logic [ROOT_BITS+1:0]   rem_sh;
  logic [ROOT_BITS+1:0]   trial;
  logic                   fits;

  // Bring down the next two radicand bits and try the next root bit.
  assign rem_sh = {rem_q[ROOT_BITS-1:0], rad_q[2*ROOT_BITS-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(ROOT_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*ROOT_BITS-3:0], 2'b00};
      rem_q  <= fits ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ROOT_BITS-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;
endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// Waypoint route search testbench
// Builds a waypoint graph, asks for routes, and checks each result beat field
// by field against an A* predictor held inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import wasr_pkg::*;

  localparam int unsigned NPTS = DEF_MAX_POINTS;
  localparam int unsigned NNB  = DEF_MAX_NEIGHBORS;
  localparam int unsigned NONE = 63;
  // Action code that the block must ignore without any result beat.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         act;
    logic signed [15:0] px, py, pz, gx, gy, gz;
    logic [4:0]         src, dst;
    bit                 typed;   // expected status typed into the row
    status_e            st;
  } req_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic               last;
    logic [1:0]         status;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wasr_in_if  req_if ();
  wasr_out_if res_if ();

  waypoint_astar_route_search dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  always #4 clk_i = ~clk_i;

  // Shadow of the waypoint store kept by the predictor.
  int    way_n;
  int    way_pos[NPTS][3];
  int    link_n[NPTS];
  int    link_to[NPTS][NNB];
  beat_t route_q[$];
  int    fail_n;
  int    idle_phase;   // 0: sender 37%, receiver 76%; 1: swapped; 2: no idling

  function automatic longint unsigned sq_len(int ax, int ay, int az, int bx, int by, int bz);
    longint dx, dy, dz;
    dx = ax - bx;
    dy = ay - by;
    dz = az - bz;
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic int floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return int'(r);
  endfunction

  function automatic int hop(int a, int b);
    return floor_root(sq_len(way_pos[a][0], way_pos[a][1], way_pos[a][2],
                             way_pos[b][0], way_pos[b][1], way_pos[b][2]));
  endfunction

  function automatic int cost_add(int a, int b);
    longint s;
    s = longint'(a) + b;
    return (s > COST_MAX) ? int'(COST_MAX) : int'(s);
  endfunction

  function automatic int snap(int x, int y, int z);
    int best;
    longint unsigned bd, d;
    best = 0;
    bd = sq_len(way_pos[0][0], way_pos[0][1], way_pos[0][2], x, y, z);
    for (int i = 1; i < way_n; i++) begin
      d = sq_len(way_pos[i][0], way_pos[i][1], way_pos[i][2], x, y, z);
      if (d < bd) begin
        bd = d;
        best = i;
      end
    end
    return best;
  endfunction

  function automatic beat_t flag_beat(status_e st);
    beat_t b;
    b.x = '0; b.y = '0; b.z = '0; b.last = 1'b1; b.status = st;
    return b;
  endfunction

  // Appends one beat to the tail of the expected queue.
  function automatic void expect_beat(beat_t b);
    route_q.insert(route_q.size(), b);
  endfunction

  // Updates the shadow store and queues the beats that one request causes.
  function automatic void predict_route(req_t r);
    int g[NPTS], f[NPTS], par[NPTS];
    bit op[NPTS], cl[NPTS];
    int s, e, cur, nb, nc, wp, nx;
    bit done;
    beat_t b;
    if (r.act == ACT_ADD_POINT) begin
      if (way_n >= NPTS) begin
        expect_beat(flag_beat(ST_FULL));
      end else begin
        way_pos[way_n][0] = int'(r.px);
        way_pos[way_n][1] = int'(r.py);
        way_pos[way_n][2] = int'(r.pz);
        link_n[way_n] = 0;
        way_n++;
        expect_beat(flag_beat(ST_OK));
      end
    end else if (r.act == ACT_ADD_LINK) begin
      if (r.src >= way_n || r.dst >= way_n) begin
        expect_beat(flag_beat(ST_BAD_INDEX));
      end else if (link_n[r.src] >= NNB) begin
        expect_beat(flag_beat(ST_FULL));
      end else begin
        link_to[r.src][link_n[r.src]] = int'(r.dst);
        link_n[r.src]++;
        expect_beat(flag_beat(ST_OK));
      end
    end else if (r.act == ACT_ROUTE) begin
      if (way_n == 0) begin
        expect_beat(flag_beat(ST_NO_ROUTE));
        return;
      end
      for (int i = 0; i < NPTS; i++) begin
        g[i] = 0; f[i] = 0; par[i] = NONE; op[i] = 0; cl[i] = 0;
      end
      s = snap(int'(r.px), int'(r.py), int'(r.pz));
      e = snap(int'(r.gx), int'(r.gy), int'(r.gz));
      f[s] = cost_add(0, hop(s, e));
      op[s] = 1;
      done = 0;
      while (!done) begin
        cur = NONE;
        for (int i = 0; i < way_n; i++)
          if (op[i] && (cur == NONE || f[i] < f[cur])) cur = i;
        // An open list that runs dry means the goal is unreachable.
        if (cur == NONE) begin
          expect_beat(flag_beat(ST_NO_ROUTE));
          return;
        end
        op[cur] = 0;
        cl[cur] = 1;
        if (cur == e) begin
          done = 1;
        end else begin
          for (int k = 0; k < link_n[cur]; k++) begin
            nb = link_to[cur][k];
            if (nb < way_n && !cl[nb]) begin
              nc = cost_add(g[cur], hop(cur, nb));
              if (nc < g[nb] || !op[nb]) begin
                g[nb] = nc;
                f[nb] = cost_add(nc, hop(nb, e));
                par[nb] = cur;
                op[nb] = 1;
              end
            end
          end
        end
      end
      b.x = r.gx; b.y = r.gy; b.z = r.gz; b.last = 1'b0; b.status = ST_OK;
      expect_beat(b);
      wp = e;
      for (int st = 0; st < way_n; st++) begin
        nx = par[wp];
        b.x = 16'(way_pos[wp][0]);
        b.y = 16'(way_pos[wp][1]);
        b.z = 16'(way_pos[wp][2]);
        b.last = (nx >= way_n) || (st + 1 == way_n);
        expect_beat(b);
        if (b.last) break;
        wp = nx;
      end
    end
  endfunction

  // Drives one request beat from a falling edge and holds it until accepted.
  task automatic send_req(req_t r);
    int idle_pct;
    idle_pct = (idle_phase == 0) ? 37 : (idle_phase == 1) ? 76 : 0;
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    = 1'b1;
    req_if.action   = r.act;
    req_if.pos_x    = r.px;
    req_if.pos_y    = r.py;
    req_if.pos_z    = r.pz;
    req_if.goal_x   = r.gx;
    req_if.goal_y   = r.gy;
    req_if.goal_z   = r.gz;
    req_if.link_src = r.src;
    req_if.link_dst = r.dst;
    do @(posedge clk_i); while (!req_if.ready);
    // Rows with a typed result check the block against the typed status.
    if (r.typed) begin
      predict_route(r);
      if (r.act != ACT_UNUSED) void'(route_q.pop_back());
      if (r.act != ACT_UNUSED) expect_beat(flag_beat(r.st));
    end else begin
      predict_route(r);
    end
    @(negedge clk_i);
  endtask

  // The receiver stalls at a rate set by the idling phase.
  always @(negedge clk_i) begin
    if (idle_phase == 0) res_if.ready <= ($urandom_range(99) >= 76);
    else if (idle_phase == 1) res_if.ready <= ($urandom_range(99) >= 37);
    else res_if.ready <= 1'b1;
  end

  // Each accepted result beat is compared with the oldest expected beat.
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (route_q.size() == 0) begin
        fail_n++;
        if (fail_n <= 10) $display("unexpected result beat x=%0d y=%0d z=%0d",
                                   res_if.out_x, res_if.out_y, res_if.out_z);
      end else begin
        want = route_q.pop_front();
        if (res_if.out_x !== want.x || res_if.out_y !== want.y ||
            res_if.out_z !== want.z || res_if.last !== want.last ||
            res_if.status !== want.status) begin
          fail_n++;
          if (fail_n <= 10)
            $display({"beat differs: expected %0d %0d %0d last=%0d st=%0d, ",
                      "got %0d %0d %0d last=%0d st=%0d"},
                     want.x, want.y, want.z, want.last, want.status, res_if.out_x,
                     res_if.out_y, res_if.out_z, res_if.last, res_if.status);
        end
      end
    end
  end

  function automatic req_t make_row(logic [1:0] act, int px, int py, int pz, int gx,
                                    int gy, int gz, int src, int dst, bit typed,
                                    status_e st);
    req_t r;
    r.act = act;
    r.px = 16'(px); r.py = 16'(py); r.pz = 16'(pz);
    r.gx = 16'(gx); r.gy = 16'(gy); r.gz = 16'(gz);
    r.src = 5'(src); r.dst = 5'(dst); r.typed = typed; r.st = st;
    return r;
  endfunction

  // Coordinates mostly sit in a small cluster so that routes snap to distinct
  // waypoints; the rest span the whole signed range.
  function automatic int pick_coord();
    if ($urandom_range(99) < 60) return $urandom_range(400) - 200;
    return $signed(16'($urandom));
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int sel, w;
    r = make_row(ACT_ADD_POINT, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                 pick_coord(), pick_coord(), $urandom_range(31), $urandom_range(31), 0, ST_OK);
    sel = $urandom_range(99);
    if (sel < 3) begin
      r.act = ACT_UNUSED;
    end else if (sel < 33) begin
      r.act = ACT_ADD_POINT;
    end else if (sel < 73) begin
      r.act = ACT_ADD_LINK;
      if (way_n > 0 && $urandom_range(9) != 0) begin
        r.src = 5'($urandom_range(way_n - 1));
        r.dst = 5'($urandom_range(way_n - 1));
      end
    end else begin
      r.act = ACT_ROUTE;
      // Most route ends sit close to a stored waypoint.
      if (way_n > 0 && $urandom_range(3) != 0) begin
        w = $urandom_range(way_n - 1);
        r.px = 16'(way_pos[w][0] + int'($urandom_range(6)) - 3);
        r.py = 16'(way_pos[w][1]);
        r.pz = 16'(way_pos[w][2]);
        w = $urandom_range(way_n - 1);
        r.gx = 16'(way_pos[w][0]);
        r.gy = 16'(way_pos[w][1] + int'($urandom_range(6)) - 3);
        r.gz = 16'(way_pos[w][2]);
      end
    end
    return r;
  endfunction

  req_t rows[$];
  req_t rq;

  function automatic void add_row(req_t r);
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    req_if.valid = 1'b0;
    req_if.action = ACT_ADD_POINT;
    {req_if.pos_x, req_if.pos_y, req_if.pos_z} = '0;
    {req_if.goal_x, req_if.goal_y, req_if.goal_z} = '0;
    req_if.link_src = '0;
    req_if.link_dst = '0;
    res_if.ready = 1'b0;
    way_n = 0;
    fail_n = 0;
    idle_phase = 0;

    // Directed rows: empty store cases, coordinate extremes, a short chain,
    // start equal to goal, an unreachable goal, self and duplicate links and
    // a full neighbor list.
    add_row(make_row(ACT_ROUTE, 0, 0, 0, 5, 5, 5, 0, 0, 1, ST_NO_ROUTE));
    add_row(make_row(ACT_ADD_LINK, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_BAD_INDEX));
    add_row(make_row(ACT_UNUSED, -1, -1, -1, -1, -1, -1, 31, 31, 1, ST_OK));
    add_row(make_row(ACT_ADD_POINT, 32767, 32767, 32767, 0, 0, 0, 0, 0, 1, ST_OK));
    add_row(make_row(ACT_ADD_POINT, -32768, -32768, -32768, 0, 0, 0, 0, 0, 1, ST_OK));
    add_row(make_row(ACT_ADD_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK));
    add_row(make_row(ACT_ADD_LINK, 0, 0, 0, 0, 0, 0, 0, 1, 1, ST_OK));
    add_row(make_row(ACT_ADD_LINK, 0, 0, 0, 0, 0, 0, 1, 2, 1, ST_OK));
    add_row(make_row(ACT_ADD_LINK, 0, 0, 0, 0, 0, 0, 2, 31, 1, ST_BAD_INDEX));
    add_row(make_row(ACT_ADD_LINK, 0, 0, 0, 0, 0, 0, 31, 0, 1, ST_BAD_INDEX));
    add_row(make_row(ACT_ROUTE, 32000, 32767, 32767, 1, 1, 1, 0, 0, 0, ST_OK));
    add_row(make_row(ACT_ROUTE, 5, 5, 5, -3, 2, 1, 0, 0, 0, ST_OK));
    add_row(make_row(ACT_ROUTE, 0, 0, 0, 32767, 32767, 32767, 0, 0, 0, ST_OK));
    for (int i = 0; i < 5; i++)
      add_row(make_row(ACT_ADD_LINK, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK));
    add_row(make_row(ACT_ADD_LINK, 0, 0, 0, 0, 0, 0, 0, 2, 1, ST_OK));
    add_row(make_row(ACT_ADD_LINK, 0, 0, 0, 0, 0, 0, 0, 1, 1, ST_OK));
    add_row(make_row(ACT_ADD_LINK, 0, 0, 0, 0, 0, 0, 0, 2, 1, ST_FULL));
    add_row(make_row(ACT_ROUTE, 32767, 32767, 32767, -32768, -32768, -32768,
                     0, 0, 0, ST_OK));

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_req(rows[i]);

    for (int n = 0; n < 268; n++) begin
      if (n == 90) idle_phase = 1;
      if (n == 180) idle_phase = 2;
      // Hold the sender back once until the block has drained completely.
      if (n == 135) begin
        req_if.valid = 1'b0;
        while (route_q.size() != 0) @(negedge clk_i);
      end
      rq = rand_req();
      send_req(rq);
    end
    req_if.valid = 1'b0;

    while (route_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_n == 0) $display("waypoint_astar_route_search: match");
    else $display("waypoint_astar_route_search: mismatch");
    $finish;
  end

  // Safety net well beyond the slowest correct run.
  initial begin
    #160000000;
    $display("waypoint_astar_route_search: mismatch");
    $finish;
  end

endmodule

### waypoint_astar_route_search.f
sv/wasr_pkg.sv
sv/wasr_if.sv
sv/wasr_isqrt.sv
sv/waypoint_astar_route_search.sv
test/tb_top.sv
